@@ design/ird_pkg.sv @@
// Shared types, constants and a helper function for the integer to radix text converter.
// No dependencies; every other file of the block refers to this package by scoped names.
package ird_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CharW = 7;
  localparam int unsigned RadixW = 6;
  localparam int unsigned MaxChars = 33;

  // Radix limits and the fallback used for out-of-range register values.
  localparam logic [RadixW-1:0] RadixReset = RadixW'(10);
  localparam logic [RadixW-1:0] RadixFallback = RadixW'(10);
  localparam logic [RadixW-1:0] RadixMin = RadixW'(2);
  localparam logic [RadixW-1:0] RadixMax = RadixW'(36);

  // The divider consumes this many dividend bits per cycle.
  localparam int unsigned DivBits = 8;
  localparam int unsigned DivSteps = ValueW / DivBits;

  localparam logic [CharW-1:0] MinusCode = CharW'(45);
  localparam logic [CharW-1:0] ZeroCode = CharW'(48);
  localparam logic [CharW-1:0] LetterBase = CharW'(87);

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [CharW-1:0] char_t;
  typedef logic [RadixW-1:0] radix_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_SIGN,
    ST_EMIT
  } ird_state_e;

  // Map a digit value 0..35 to '0'..'9' or 'a'..'z'.
  function automatic char_t digit_code(input radix_t d);
    char_t code;
    if (d < RadixW'(10)) begin
      code = ZeroCode + CharW'(d);
    end else begin
      code = LetterBase + CharW'(d);
    end
    return code;
  endfunction

endpackage

@@ design/ird_if.sv @@
// Valid/ready channel interfaces for the integer to radix text converter.
// Depends on ird_pkg for the payload types.
interface ird_in_if;
  logic            valid;
  logic            ready;
  ird_pkg::value_t value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface ird_out_if;
  logic           valid;
  logic           ready;
  ird_pkg::char_t char_code;
  logic           last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink (input valid, input char_code, input last, output ready);
endinterface

interface ird_cfg_if;
  logic            valid;
  logic            ready;
  ird_pkg::radix_t radix;

  modport source (output valid, output radix, input ready);
  modport sink (input valid, input radix, output ready);
endinterface

@@ design/int_to_radix_digits.sv @@
// Top level of the integer to radix text converter: sequencer, shared divider and digit store.
// Depends on ird_pkg and the channel interfaces in ird_if.sv.

// The block takes one signed 32-bit integer per input request and returns its text in the
// radix held in the configuration register, one ASCII character per output request, most
// significant character first, with a leading '-' for negative values and last set on the
// final character. A radix register value outside 2..36 behaves as 10; the register resets
// to 10 and is written through the configuration channel, which is always ready. The block
// takes one number at a time and is not ready for input until the final character of the
// previous number has been taken. A number is accepted, divided digit by digit, the top
// digit is fetched from the store, a minus sign is offered if the value is negative, and
// then the digits are offered while the output side is ready. The most negative value in
// binary has 32 digits. The pace is set by the single shared divider, which retires 8
// dividend bits per cycle and thus needs four passes per digit, and by the single read
// port of the digit store.
module int_to_radix_digits #(
  parameter int unsigned MAX_CHARS = ird_pkg::MaxChars
) (
  input logic         clk_i,
  input logic         rst_ni,
  ird_in_if.sink      in_i,
  ird_out_if.source   out_o,
  ird_cfg_if.sink     cfg_i
);

  localparam int unsigned AddrW = $clog2(MAX_CHARS);
  localparam int unsigned StepW = $clog2(ird_pkg::DivSteps);
  localparam int unsigned ValW = ird_pkg::ValueW;
  localparam int unsigned RadW = ird_pkg::RadixW;
  localparam int unsigned DivB = ird_pkg::DivBits;

  typedef logic [AddrW-1:0] addr_t;

  ird_pkg::ird_state_e state_q, state_d;

  ird_pkg::radix_t radix_q;
  ird_pkg::radix_t base_q;
  ird_pkg::radix_t eff_base;
  logic            neg_q;
  logic [ValW-1:0] work_q;
  ird_pkg::radix_t rem_q;
  logic [StepW-1:0] step_q;
  addr_t           cnt_q;
  ird_pkg::radix_t rd_q;

  // Digit store, least significant digit at address zero.
  ird_pkg::radix_t digit_mem [MAX_CHARS];

  logic in_acc;
  logic out_acc;
  logic cfg_acc;

  // Shared divider signals.
  logic [RadW:0]     trial;
  ird_pkg::radix_t   rem_nxt;
  logic [DivB-1:0]   quo_bits;
  logic [ValW-1:0]   work_shift;
  logic              last_step;
  logic              div_done;
  logic              mem_we;
  logic              rd_en;
  addr_t             rd_addr;

  assign in_acc = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;

  always_comb begin
    if (radix_q inside {[ird_pkg::RadixMin:ird_pkg::RadixMax]}) begin
      eff_base = radix_q;
    end else begin
      eff_base = ird_pkg::RadixFallback;
    end
  end

  // One pass of the divider: restoring division of the top byte of the working word by the
  // radix, carrying the partial remainder in from the previous pass. Quotient bits are
  // shifted into the bottom, so after four passes the working word holds the full quotient.
  always_comb begin
    rem_nxt = rem_q;
    quo_bits = '0;
    trial = '0;
    for (int i = DivB - 1; i >= 0; i--) begin
      trial = {rem_nxt, work_q[ValW-DivB+i]};
      if (trial >= {1'b0, base_q}) begin
        quo_bits[i] = 1'b1;
        trial = trial - {1'b0, base_q};
      end
      rem_nxt = trial[RadW-1:0];
    end
  end

  assign work_shift = {work_q[ValW-DivB-1:0], quo_bits};
  assign last_step = (step_q == StepW'(ird_pkg::DivSteps - 1));
  // The digit loop stops on a zero quotient or when the digit store is one short of full.
  assign div_done = last_step &&
                    ((work_shift == '0) || (addr_t'(cnt_q + 1'b1) == addr_t'(MAX_CHARS - 1)));

  assign mem_we = (state_q == ird_pkg::ST_DIV) && last_step;
  assign rd_addr = cnt_q - 1'b1;
  assign rd_en = (state_q == ird_pkg::ST_PREP) ||
                 ((state_q == ird_pkg::ST_EMIT) && out_acc && (cnt_q != '0));

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ird_pkg::ST_IDLE: begin
        if (in_acc) state_d = ird_pkg::ST_DIV;
      end
      ird_pkg::ST_DIV: begin
        if (div_done) state_d = ird_pkg::ST_PREP;
      end
      ird_pkg::ST_PREP: begin
        state_d = neg_q ? ird_pkg::ST_SIGN : ird_pkg::ST_EMIT;
      end
      ird_pkg::ST_SIGN: begin
        if (out_acc) state_d = ird_pkg::ST_EMIT;
      end
      ird_pkg::ST_EMIT: begin
        if (out_acc && (cnt_q == '0)) state_d = ird_pkg::ST_IDLE;
      end
      default: begin
        state_d = ird_pkg::ST_IDLE;
      end
    endcase
  end

  // Handshake and payload outputs. In the emit state the read register holds the digit at
  // index cnt_q, so the final character is the one at index zero.
  always_comb begin
    in_i.ready = 1'b0;
    out_o.valid = 1'b0;
    out_o.char_code = ird_pkg::digit_code(rd_q);
    out_o.last = 1'b0;
    case (state_q)
      ird_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
      end
      ird_pkg::ST_SIGN: begin
        out_o.valid = 1'b1;
        out_o.char_code = ird_pkg::MinusCode;
      end
      ird_pkg::ST_EMIT: begin
        out_o.valid = 1'b1;
        out_o.last = (cnt_q == '0);
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ird_pkg::ST_IDLE;
      radix_q <= ird_pkg::RadixReset;
      base_q <= ird_pkg::RadixFallback;
      neg_q <= 1'b0;
      work_q <= '0;
      rem_q <= '0;
      step_q <= '0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) begin
        radix_q <= cfg_i.radix;
      end
      case (state_q)
        ird_pkg::ST_IDLE: begin
          if (in_acc) begin
            neg_q <= in_i.value[ValW-1];
            // The magnitude is taken as unsigned, so the most negative value maps to 2^31.
            work_q <= in_i.value[ValW-1] ? ValW'(-in_i.value) : ValW'(in_i.value);
            base_q <= eff_base;
            rem_q <= '0;
            step_q <= '0;
            cnt_q <= '0;
          end
        end
        ird_pkg::ST_DIV: begin
          work_q <= work_shift;
          if (last_step) begin
            rem_q <= '0;
            step_q <= '0;
            cnt_q <= cnt_q + 1'b1;
          end else begin
            rem_q <= rem_nxt;
            step_q <= step_q + 1'b1;
          end
        end
        ird_pkg::ST_PREP: begin
          cnt_q <= cnt_q - 1'b1;
        end
        ird_pkg::ST_EMIT: begin
          if (out_acc && (cnt_q != '0)) begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
    end
  end

  // Digit store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[cnt_q] <= rem_nxt;
    end
    if (rd_en) begin
      rd_q <= digit_mem[rd_addr];
    end
  end

  // The input side is never ready while a character is offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input ready while a character is pending");

  // The partial remainder always stays below the latched radix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ird_pkg::ST_DIV) |-> (rem_q < base_q))
    else $error("divider remainder not below radix");

  // The latched radix is always a legal base.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ird_pkg::ST_IDLE) |->
      ((base_q >= ird_pkg::RadixMin) && (base_q <= ird_pkg::RadixMax)))
    else $error("latched radix out of range");

  // The digit count never passes the store limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= addr_t'(MAX_CHARS - 1))
    else $error("digit count overflow");

  // After the final character is taken the block is ready for the next number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.last) |=> in_i.ready)
    else $error("block not ready after final character");

endmodule
